[sv/apc_pkg.sv]
`default_nettype none
package apc_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } apc_op_t;

  typedef enum logic [2:0] {
    ACT_WAIT     = 3'd0,
    ACT_TASKFILE = 3'd1,
    ACT_PACKET   = 3'd2,
    ACT_READ     = 3'd3,
    ACT_WRITE    = 3'd4,
    ACT_DONE     = 3'd5
  } apc_action_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_BUSY  = 2'd2,
    PH_DATA  = 2'd3
  } apc_phase_t;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_CMD_BUSY_TO  = 4'd1;
  localparam logic [3:0] ERR_PACKET_STAT  = 4'd2;
  localparam logic [3:0] ERR_DATA_WAIT_TO = 4'd3;
  localparam logic [3:0] ERR_DATA_STAT    = 4'd4;
  localparam logic [3:0] ERR_FINAL_TO     = 4'd5;
  localparam logic [3:0] ERR_FINAL        = 4'd6;
  localparam logic [3:0] ERR_OVERRUN      = 4'd7;
  localparam logic [3:0] ERR_ZERO_COUNT   = 4'd8;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MAX_BYTES      = 2'd0;
  localparam logic [1:0] REG_USE_INTERRUPTS = 2'd1;
  localparam logic [1:0] REG_DEVICE_SELECT  = 2'd2;

  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [16:0] MAX_BYTES_RESET = 17'd32768;

  // Status and interrupt reason bit positions
  localparam int unsigned ST_BSY = 7;
  localparam int unsigned ST_DRQ = 3;
  localparam int unsigned ST_ERR = 0;
  localparam int unsigned RS_CD  = 0;
  localparam int unsigned RS_IO  = 1;

  localparam logic [3:0] PACKET_WORDS_12 = 4'd6;
  localparam logic [3:0] PACKET_WORDS_16 = 4'd8;
  localparam logic [4:0] SHORT_PACKET_BYTES = 5'd12;

  localparam logic [7:0] DEV_CTRL_BASE = 8'h08;
  localparam logic [7:0] DEV_CTRL_NIEN = 8'h02;
  localparam logic [7:0] DEV_HEAD_MASTER = 8'hA0;
  localparam logic [7:0] DEV_HEAD_SLAVE  = 8'hB0;

  typedef struct packed {
    apc_op_t     operation;
    logic [15:0] byte_limit;
    logic        write_dir;
    logic [4:0]  command_bytes;
    logic [7:0]  status_reg;
    logic [7:0]  reason_reg;
    logic [7:0]  count_low;
    logic [7:0]  count_high;
  } apc_item_t;

  typedef struct packed {
    apc_action_t action;
    logic [15:0] word_count;
    logic [3:0]  error_code;
    logic [8:0]  fail_bits;
    logic [17:0] total_bytes;
    logic [15:0] drq_blocks;
    logic        no_data;
    logic [7:0]  device_control;
    logic [7:0]  device_head;
  } apc_result_t;

  typedef struct packed {
    logic [16:0] max_bytes;
    logic        use_interrupts;
    logic        device_select;
  } apc_cfg_t;

  typedef struct packed {
    apc_phase_t  phase;
    logic [15:0] limit_bytes;
    logic        dir_write;
    logic [3:0]  packet_words;
    logic [3:0]  error_state;
    logic [8:0]  fail_state;
    logic [17:0] byte_total;
    logic [15:0] block_count;
    logic        odd_pending;
    logic [7:0]  last_reason;
  } apc_state_t;

endpackage
`default_nettype wire

[sv/apc_cfg.sv]
`default_nettype none
module apc_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [apc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output apc_pkg::apc_cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes      <= apc_pkg::MAX_BYTES_RESET;
      cfg.use_interrupts <= 1'b0;
      cfg.device_select  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apc_pkg::REG_MAX_BYTES:      cfg.max_bytes      <= cfg_data;
        apc_pkg::REG_USE_INTERRUPTS: cfg.use_interrupts <= cfg_data[0];
        apc_pkg::REG_DEVICE_SELECT:  cfg.device_select  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/apc_step.sv]
`default_nettype none
module apc_step (
  input  wire apc_pkg::apc_item_t  item,
  input  wire apc_pkg::apc_state_t state,
  input  wire apc_pkg::apc_cfg_t   cfg,
  output apc_pkg::apc_state_t  state_next,
  output apc_pkg::apc_result_t result
);

  logic [7:0]  st;
  logic [7:0]  rs;
  logic [15:0] cnt;
  logic [18:0] sum;
  logic [15:0] words;
  logic        end_cmd;
  logic [7:0]  end_reason;

  assign st    = item.status_reg;
  assign rs    = item.reason_reg;
  assign cnt   = {item.count_high, item.count_low};
  assign sum   = {1'b0, state.byte_total} + {3'b000, cnt};
  assign words = {1'b0, cnt[15:1]} + {15'd0, cnt[0]};

  always_comb begin
    state_next = state;
    result     = '0;
    result.action = apc_pkg::ACT_WAIT;
    end_cmd    = 1'b0;
    end_reason = rs;

    unique case (item.operation)
      apc_pkg::OP_START: begin
        state_next.limit_bytes  = item.byte_limit;
        state_next.dir_write    = item.write_dir;
        state_next.packet_words = (item.command_bytes > apc_pkg::SHORT_PACKET_BYTES) ?
                                  apc_pkg::PACKET_WORDS_16 : apc_pkg::PACKET_WORDS_12;
        state_next.error_state  = apc_pkg::ERR_NONE;
        state_next.fail_state   = '0;
        state_next.byte_total   = '0;
        state_next.block_count  = '0;
        state_next.odd_pending  = 1'b0;
        state_next.last_reason  = '0;
        state_next.phase        = apc_pkg::PH_FIRST;
        result.action           = apc_pkg::ACT_TASKFILE;
        result.device_control   = apc_pkg::DEV_CTRL_BASE |
                                  (cfg.use_interrupts ? 8'h00 : apc_pkg::DEV_CTRL_NIEN);
        result.device_head      = cfg.device_select ? apc_pkg::DEV_HEAD_SLAVE :
                                                      apc_pkg::DEV_HEAD_MASTER;
      end
      apc_pkg::OP_SAMPLE: begin
        if (state.phase != apc_pkg::PH_IDLE) begin
          state_next.last_reason = rs;
          unique case (state.phase)
            apc_pkg::PH_FIRST: begin
              // busy already gone with neither DRQ nor ERR: device missed the command
              if (!st[apc_pkg::ST_BSY] && !st[apc_pkg::ST_DRQ] && !st[apc_pkg::ST_ERR])
                state_next.fail_state[0] = 1'b1;
              state_next.phase = apc_pkg::PH_BUSY;
            end
            apc_pkg::PH_BUSY: begin
              if (st[apc_pkg::ST_BSY]) begin
                result.action = apc_pkg::ACT_WAIT;
              end else if (!st[apc_pkg::ST_DRQ] || st[apc_pkg::ST_ERR]) begin
                state_next.error_state = apc_pkg::ERR_PACKET_STAT;
                end_cmd = 1'b1;
              end else begin
                if ((rs[7:1] != 7'd0) || !rs[apc_pkg::RS_CD])
                  state_next.fail_state[2] = 1'b1;
                if (cnt != state.limit_bytes)
                  state_next.fail_state[3] = 1'b1;
                result.action     = apc_pkg::ACT_PACKET;
                result.word_count = {12'd0, state.packet_words};
                state_next.phase  = apc_pkg::PH_DATA;
              end
            end
            apc_pkg::PH_DATA: begin
              if (st[apc_pkg::ST_BSY]) begin
                result.action = apc_pkg::ACT_WAIT;
              end else if (!st[apc_pkg::ST_DRQ]) begin
                // reuse this sample as the final status
                if (st[apc_pkg::ST_ERR])
                  state_next.error_state = apc_pkg::ERR_FINAL;
                end_cmd = 1'b1;
              end else begin
                if ((rs[7:2] != 6'd0) || rs[apc_pkg::RS_CD])
                  state_next.fail_state[4] = 1'b1;
                if (rs[apc_pkg::RS_IO] && state.dir_write)
                  state_next.fail_state[5] = 1'b1;
                if (cnt == 16'd0) begin
                  state_next.error_state = apc_pkg::ERR_ZERO_COUNT;
                  end_cmd = 1'b1;
                end else begin
                  if (cnt > state.limit_bytes)
                    state_next.fail_state[6] = 1'b1;
                  if (state.odd_pending)
                    state_next.fail_state[7] = 1'b1;
                  state_next.odd_pending = cnt[0];
                  if (sum > {2'b00, cfg.max_bytes}) begin
                    state_next.error_state = apc_pkg::ERR_OVERRUN;
                    end_cmd = 1'b1;
                  end else begin
                    if (state.block_count != 16'hFFFF)
                      state_next.block_count = state.block_count + 16'd1;
                    result.word_count     = words;
                    state_next.byte_total = state.byte_total + {1'b0, words, 1'b0};
                    result.action = state.dir_write ? apc_pkg::ACT_WRITE :
                                                      apc_pkg::ACT_READ;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      apc_pkg::OP_TIMEOUT: begin
        if (state.phase != apc_pkg::PH_IDLE) begin
          state_next.error_state = (state.phase == apc_pkg::PH_DATA) ?
                                   apc_pkg::ERR_DATA_WAIT_TO : apc_pkg::ERR_CMD_BUSY_TO;
          end_reason = state.last_reason;
          end_cmd    = 1'b1;
        end
      end
      default: ;
    endcase

    if (end_cmd) begin
      // final interrupt reason must read CD and IO with nothing else set
      if ((end_reason[7:2] != 6'd0) || !end_reason[apc_pkg::RS_IO] ||
          !end_reason[apc_pkg::RS_CD])
        state_next.fail_state[8] = 1'b1;
      state_next.phase = apc_pkg::PH_IDLE;
      result.action    = apc_pkg::ACT_DONE;
    end

    result.error_code  = state_next.error_state;
    result.fail_bits   = state_next.fail_state;
    result.total_bytes = state_next.byte_total;
    result.drq_blocks  = state_next.block_count;
    result.no_data     = (result.action == apc_pkg::ACT_DONE) &&
                         (state_next.byte_total == 18'd0);
  end

endmodule
`default_nettype wire

[sv/atapi_pio_packet_checker_core.sv]
`default_nettype none
// Host-side ATAPI PIO packet-command sequencer. Each accepted word (start,
// register sample or timeout) yields exactly one result word carrying the
// next action, word count, error code, protocol fail flags, byte total and
// DRQ block count. A word passes through the input register and then the
// result register, and one word is taken every cycle while the result
// side keeps up; a stalled result holds the input register, which then
// stalls the item side. Configuration writes are taken at any time but
// should only be issued while idle.
module atapi_pio_packet_checker_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire apc_pkg::apc_item_t             item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output apc_pkg::apc_result_t                result,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [apc_pkg::CFG_DATA_W-1:0] cfg_data
);

  apc_pkg::apc_cfg_t    cfg;
  apc_pkg::apc_state_t  state;
  apc_pkg::apc_state_t  state_next;
  apc_pkg::apc_item_t   pend;
  apc_pkg::apc_result_t step_result;
  logic                 pend_valid;
  logic                 advance;

  apc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  apc_step u_step (
    .item       (pend),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_result)
  );

  assign advance    = pend_valid && (!result_valid || !result_stall);
  assign item_stall = pend_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!item_stall) begin
      pend_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      pend <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= apc_pkg::PH_IDLE;
      state.limit_bytes  <= '0;
      state.dir_write    <= 1'b0;
      state.packet_words <= apc_pkg::PACKET_WORDS_12;
      state.error_state  <= apc_pkg::ERR_NONE;
      state.fail_state   <= '0;
      state.byte_total   <= '0;
      state.block_count  <= '0;
      state.odd_pending  <= 1'b0;
      state.last_reason  <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  // A done result always leaves the sequencer idle behind it
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.action == apc_pkg::ACT_DONE) |-> state.phase == apc_pkg::PH_IDLE)
    else $error("done result while sequencer not idle");

  // Word count only on packet and data actions
  a_wc_action: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.word_count != 16'd0) |->
      (result.action == apc_pkg::ACT_PACKET || result.action == apc_pkg::ACT_READ ||
       result.action == apc_pkg::ACT_WRITE))
    else $error("word count on a non-transfer action");

  // Input register never drops a word: a held word stays when the output is stalled
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && result_valid && result_stall) |=> (pend_valid && $stable(pend)))
    else $error("pending word lost under stall");

  // Results reflect state: totals match the committed state after each step
  a_total_state: assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> (result.total_bytes == state.byte_total &&
                        result.drq_blocks == state.block_count))
    else $error("result totals disagree with state");

endmodule
`default_nettype wire

[bench/atapi_pio_packet_checker_core_test.sv]
module atapi_pio_packet_checker_core_test;
  import apc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;
  localparam int REL_BIT = 2;

  localparam logic [7:0] STAT_BSY = 8'h01 << ST_BSY;
  localparam logic [7:0] STAT_DRQ = 8'h01 << ST_DRQ;
  localparam logic [7:0] STAT_ERR = 8'h01 << ST_ERR;
  localparam logic [7:0] STAT_OTHER = ~(STAT_BSY | STAT_DRQ | STAT_ERR);
  localparam logic [7:0] REASON_CD = 8'h01 << RS_CD;
  localparam logic [7:0] REASON_IO = 8'h01 << RS_IO;
  localparam logic [7:0] REASON_STATUS = REASON_CD | REASON_IO;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  apc_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  apc_result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MAX_BYTES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Sequencer state as the host driver sees it
  int unsigned cap_bytes;
  logic irq_on;
  logic slave_sel;
  apc_phase_t cmd_phase;
  logic [15:0] blk_limit;
  logic host_writes;
  logic [3:0] pkt_words;
  logic [3:0] err_now;
  logic [8:0] fails;
  int unsigned moved_bytes;
  logic [15:0] blocks;
  logic odd_seen;
  logic [7:0] reason_seen;

  apc_result_t pending_results[$];
  int fault_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  atapi_pio_packet_checker_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic check_field(input string name, input logic [17:0] want,
                             input logic [17:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    apc_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result %h arrived with none outstanding", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("action", 18'(want.action), 18'(result.action));
        check_field("word_count", 18'(want.word_count), 18'(result.word_count));
        check_field("error_code", 18'(want.error_code), 18'(result.error_code));
        check_field("fail_bits", 18'(want.fail_bits), 18'(result.fail_bits));
        check_field("total_bytes", want.total_bytes, result.total_bytes);
        check_field("drq_blocks", 18'(want.drq_blocks), 18'(result.drq_blocks));
        check_field("no_data", 18'(want.no_data), 18'(result.no_data));
        check_field("device_control", 18'(want.device_control),
                    18'(result.device_control));
        check_field("device_head", 18'(want.device_head), 18'(result.device_head));
      end
    end
  end

  task automatic reset_sequencer_model();
    cap_bytes = 32'(MAX_BYTES_RESET);
    irq_on = 1'b0;
    slave_sel = 1'b0;
    cmd_phase = PH_IDLE;
    blk_limit = '0;
    host_writes = 1'b0;
    pkt_words = PACKET_WORDS_12;
    err_now = ERR_NONE;
    fails = '0;
    moved_bytes = 0;
    blocks = '0;
    odd_seen = 1'b0;
    reason_seen = '0;
  endtask

  // Final status check on the reason register, then back to idle
  function automatic apc_action_t close_command(input logic [7:0] rs);
    if (|rs[7:REL_BIT] || !rs[RS_IO] || !rs[RS_CD])
      fails[8] = 1'b1;
    cmd_phase = PH_IDLE;
    return ACT_DONE;
  endfunction

  function automatic apc_result_t next_result(input apc_item_t w);
    apc_result_t r;
    int unsigned cnt;
    int unsigned words;
    r = '0;
    r.action = ACT_WAIT;
    cnt = 32'({w.count_high, w.count_low});
    case (w.operation)
      OP_START: begin
        blk_limit = w.byte_limit;
        host_writes = w.write_dir;
        pkt_words = (w.command_bytes > SHORT_PACKET_BYTES) ? PACKET_WORDS_16 : PACKET_WORDS_12;
        err_now = ERR_NONE;
        fails = '0;
        moved_bytes = 0;
        blocks = '0;
        odd_seen = 1'b0;
        reason_seen = '0;
        r.device_control = irq_on ? DEV_CTRL_BASE : (DEV_CTRL_BASE | DEV_CTRL_NIEN);
        r.device_head = slave_sel ? DEV_HEAD_SLAVE : DEV_HEAD_MASTER;
        r.action = ACT_TASKFILE;
        cmd_phase = PH_FIRST;
      end
      OP_SAMPLE: if (cmd_phase != PH_IDLE) begin
        reason_seen = w.reason_reg;
        case (cmd_phase)
          PH_FIRST: begin
            if (!w.status_reg[ST_BSY] && !w.status_reg[ST_DRQ] && !w.status_reg[ST_ERR])
              fails[0] = 1'b1;
            cmd_phase = PH_BUSY;
          end
          PH_BUSY: if (!w.status_reg[ST_BSY]) begin
            if (!w.status_reg[ST_DRQ] || w.status_reg[ST_ERR]) begin
              err_now = ERR_PACKET_STAT;
              r.action = close_command(w.reason_reg);
            end else begin
              if (|w.reason_reg[7:RS_IO] || !w.reason_reg[RS_CD])
                fails[2] = 1'b1;
              if (cnt != 32'(blk_limit))
                fails[3] = 1'b1;
              r.action = ACT_PACKET;
              r.word_count = 16'(pkt_words);
              cmd_phase = PH_DATA;
            end
          end
          default: if (!w.status_reg[ST_BSY]) begin
            if (!w.status_reg[ST_DRQ]) begin
              // final status taken from this same sample
              if (w.status_reg[ST_ERR])
                err_now = ERR_FINAL;
              r.action = close_command(w.reason_reg);
            end else begin
              if (|w.reason_reg[7:REL_BIT] || w.reason_reg[RS_CD])
                fails[4] = 1'b1;
              if (w.reason_reg[RS_IO] && host_writes)
                fails[5] = 1'b1;
              if (cnt == 0) begin
                err_now = ERR_ZERO_COUNT;
                r.action = close_command(w.reason_reg);
              end else begin
                if (cnt > 32'(blk_limit))
                  fails[6] = 1'b1;
                if (odd_seen)
                  fails[7] = 1'b1;
                odd_seen = cnt[0];
                if (moved_bytes + cnt > cap_bytes) begin
                  err_now = ERR_OVERRUN;
                  r.action = close_command(w.reason_reg);
                end else begin
                  if (blocks != 16'hFFFF)
                    blocks++;
                  words = (cnt + 32'd1) >> 1;
                  moved_bytes += 32'd2 * words;
                  r.action = host_writes ? ACT_WRITE : ACT_READ;
                  r.word_count = words[15:0];
                end
              end
            end
          end
        endcase
      end
      OP_TIMEOUT: if (cmd_phase != PH_IDLE) begin
        err_now = (cmd_phase == PH_DATA) ? ERR_DATA_WAIT_TO : ERR_CMD_BUSY_TO;
        r.action = close_command(reason_seen);
      end
      default: ;
    endcase
    r.error_code = err_now;
    r.fail_bits = fails;
    r.total_bytes = moved_bytes[17:0];
    r.drq_blocks = blocks;
    r.no_data = (r.action == ACT_DONE) && (moved_bytes == 0);
    return r;
  endfunction

  function automatic apc_item_t noise_word();
    logic [63:0] bits;
    apc_item_t w;
    bits = {$urandom, $urandom};
    w = bits[$bits(apc_item_t)-1:0];
    return w;
  endfunction

  function automatic apc_item_t start_word(input logic [15:0] limit, input logic dir,
                                           input logic [4:0] cb);
    apc_item_t w;
    w = noise_word();
    w.operation = OP_START;
    w.byte_limit = limit;
    w.write_dir = dir;
    w.command_bytes = cb;
    return w;
  endfunction

  function automatic apc_item_t sample_word(input logic [7:0] st, input logic [7:0] rs,
                                            input logic [15:0] cnt);
    apc_item_t w;
    w = noise_word();
    w.operation = OP_SAMPLE;
    w.status_reg = st;
    w.reason_reg = rs;
    w.count_low = cnt[7:0];
    w.count_high = cnt[15:8];
    return w;
  endfunction

  function automatic apc_item_t op_word(input apc_op_t op);
    apc_item_t w;
    w = noise_word();
    w.operation = op;
    return w;
  endfunction

  // Hold valid until the word is taken, then log what it must produce
  task automatic push_word(input apc_item_t w);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(next_result(w));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input int unsigned max_b, input logic irq, input logic sel);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_BYTES;
    cfg_data <= CFG_DATA_W'(max_b);
    @(posedge clk);
    cfg_index <= REG_USE_INTERRUPTS;
    cfg_data <= CFG_DATA_W'(irq);
    @(posedge clk);
    cfg_index <= REG_DEVICE_SELECT;
    cfg_data <= CFG_DATA_W'(sel);
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_bytes = max_b;
    irq_on = irq;
    slave_sel = sel;
  endtask

  task automatic test_idle_words();
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'h0010));
    push_word(op_word(OP_TIMEOUT));
    push_word(op_word(OP_NONE));
  endtask

  task automatic test_directed_commands();
    // read with odd blocks, busy polls and a clean final status
    push_word(start_word(16'hFFFF, 1'b0, 5'd0));
    push_word(sample_word(8'h00, 8'h00, 16'h0000));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'hFFFF));
    push_word(sample_word(STAT_DRQ, REASON_IO, 16'h0003));
    push_word(sample_word(STAT_DRQ, REASON_IO, 16'h0005));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(8'h00, REASON_STATUS, 16'h0000));
    // error status where the packet request should be
    push_word(start_word(16'h0000, 1'b1, 5'd16));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_ERR, REASON_STATUS, 16'h0000));
    // bad packet reason and count, then a zero-count block
    push_word(start_word(16'h0200, 1'b1, 5'd13));
    push_word(sample_word(STAT_DRQ, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, 8'hFF, 16'h1234));
    push_word(sample_word(STAT_DRQ | STAT_ERR, REASON_STATUS, 16'h0000));
    // timeout before any sample
    push_word(start_word(16'h8000, 1'b0, 5'd12));
    push_word(op_word(OP_TIMEOUT));
    // restart while busy, then a block past both limits
    push_word(start_word(16'hFFFF, 1'b0, 5'd11));
    push_word(start_word(16'h0010, 1'b0, 5'd12));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'h0010));
    push_word(sample_word(STAT_DRQ, REASON_IO, 16'hFFFF));
    // timeout in the data wait
    push_word(start_word(16'h0100, 1'b0, 5'd16));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'h0100));
    push_word(op_word(OP_TIMEOUT));
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    load_config(2, 1'b1, 1'b1);
    push_word(start_word(16'h0002, 1'b0, 5'd12));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'h0002));
    push_word(sample_word(STAT_DRQ, REASON_IO, 16'h0002));
    push_word(sample_word(STAT_DRQ, REASON_IO, 16'h0001));
    wait_results_drained();
    load_config(65536, 1'b0, 1'b0);
    push_word(start_word(16'hFFFF, 1'b1, 5'd16));
    push_word(sample_word(STAT_BSY, 8'h00, 16'h0000));
    push_word(sample_word(STAT_DRQ, REASON_CD, 16'hFFFF));
    push_word(sample_word(STAT_DRQ, 8'h00, 16'hFFFF));
    push_word(sample_word(STAT_DRQ, 8'h00, 16'h0001));
    wait_results_drained();
  endtask

  task automatic random_command();
    logic [15:0] limit;
    logic dir;
    logic [4:0] cb;
    logic [7:0] st;
    logic [7:0] rs;
    logic [15:0] cnt;
    int blocks_left;
    int pick;
    limit = $urandom_range(1) ? 16'($urandom_range(1, 512)) : 16'($urandom);
    dir = 1'($urandom_range(1));
    cb = 5'($urandom_range(16));
    push_word(start_word(limit, dir, cb));
    st = ($urandom_range(3) == 0) ? 8'($urandom) : (STAT_BSY | 8'($urandom));
    push_word(sample_word(st, 8'($urandom), 16'($urandom)));
    repeat ($urandom_range(2))
      push_word(sample_word(STAT_BSY | 8'($urandom), 8'($urandom), 16'($urandom)));
    pick = $urandom_range(9);
    if (pick == 0) begin
      push_word(op_word(OP_TIMEOUT));
      return;
    end
    if (pick == 1)
      st = 8'($urandom) & ~STAT_BSY;
    else
      st = (8'($urandom) & STAT_OTHER) | STAT_DRQ;
    rs = ($urandom_range(4) == 0) ? 8'($urandom) : REASON_CD;
    cnt = ($urandom_range(4) == 0) ? 16'($urandom) : limit;
    push_word(sample_word(st, rs, cnt));
    blocks_left = $urandom_range(5);
    while (blocks_left > 0 && cmd_phase == PH_DATA) begin
      if ($urandom_range(3) == 0)
        push_word(sample_word(STAT_BSY | 8'($urandom), 8'($urandom), 16'($urandom)));
      pick = $urandom_range(19);
      if (pick == 0)
        cnt = '0;
      else if (pick == 1)
        cnt = 16'($urandom);
      else if (pick == 2)
        cnt = limit + 16'd1;
      else
        cnt = 16'($urandom_range(1, (limit == 16'd0) ? 32'd1 : 32'(limit)));
      rs = ($urandom_range(9) == 0) ? 8'($urandom) : (dir ? 8'h00 : REASON_IO);
      push_word(sample_word((8'($urandom) & STAT_OTHER) | STAT_DRQ, rs, cnt));
      blocks_left--;
    end
    if (cmd_phase != PH_DATA)
      return;
    pick = $urandom_range(9);
    if (pick <= 6) begin
      st = $urandom_range(1) ? 8'h00 : (8'($urandom) & ~(STAT_BSY | STAT_DRQ));
      rs = ($urandom_range(4) == 0) ? 8'($urandom) : REASON_STATUS;
      push_word(sample_word(st, rs, 16'($urandom)));
    end else if (pick <= 8) begin
      push_word(op_word(OP_TIMEOUT));
    end
    // otherwise leave it open: the next start drops it
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(11) == 0)
        push_word(noise_word());
      else
        random_command();
    end
    wait_results_drained();
  endtask

  initial begin
    reset_sequencer_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 33;
    stall_pct = 65;
    test_idle_words();
    test_directed_commands();
    test_register_extremes();
    load_config(32'(MAX_BYTES_RESET), 1'b0, 1'b1);
    test_random_traffic(440);

    gap_pct = 65;
    stall_pct = 33;
    load_config($urandom_range(2, 1024), 1'b1, 1'b0);
    test_random_traffic(440);

    gap_pct = 0;
    stall_pct = 0;
    load_config($urandom_range(2, 65536), 1'($urandom_range(1)), 1'($urandom_range(1)));
    test_random_traffic(440);

    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
sv/apc_pkg.sv
sv/apc_cfg.sv
sv/apc_step.sv
sv/atapi_pio_packet_checker_core.sv
bench/atapi_pio_packet_checker_core_test.sv
